// ===== src/itsr_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt, shake and spin reporter.
// No dependencies.
package itsr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SQRT_STEPS       = 16;
    localparam int CORDIC_W         = 27;
    localparam int ANGLE_W          = 26;

    localparam logic [21:0] SPIN_K = 22'd3754938;

    localparam logic signed [ANGLE_W-1:0] ANGLE_90  = 26'sd5898240;
    localparam logic signed [17:0]        ROLL_LIM  = 18'sd23040;
    localparam logic signed [17:0]        PITCH_LIM = 18'sd11520;

    localparam logic [15:0] SHAKE_THR_RST  = 16'd3072;
    localparam logic [14:0] SPIN_DB_RST    = 15'd205;
    localparam logic [15:0] REPORT_IVL_RST = 16'd200;

    localparam logic [1:0] REG_SHAKE_THR  = 2'd0;
    localparam logic [1:0] REG_SPIN_DB    = 2'd1;
    localparam logic [1:0] REG_REPORT_IVL = 2'd2;

    localparam logic [1:0] SPIN_NONE = 2'd0;
    localparam logic [1:0] SPIN_CW   = 2'd1;
    localparam logic [1:0] SPIN_CCW  = 2'd2;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANGLE_W-1:0]  acc;
    } cordic_t;

    // round(atan(2^-i) * 65536), degrees
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] r;
        unique case (idx)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117265;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/imu_tilt_shake_spin_reporter.sv =====
// One sample at a time: a new input beat is taken only in the idle state, once the last
// sample has had four products through one shared multiplier, then two passes each through
// the shared CORDIC unit and the shared bit-serial square root unit, and its result beat
// has been loaded into the output register.
// Reset: synchronous active low; clears control and last report time, loads config defaults.
// Depends on itsr_pkg.
module imu_tilt_shake_spin_reporter
    import itsr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_z_rate[63:48], time_ms[95:64]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // roll_deg[15:0], pitch_deg[30:16], accel_magnitude[46:31], shake[47],
    // spin_rate[63:48], spin_dir[65:64], report[66], zero[71:67]
    output logic [71:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int RUN_LEN  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int CNT_W    = $clog2(RUN_LEN);
    localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(RUN_LEN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD1,
        S_RUN1,
        S_LOAD2,
        S_RUN2,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2:0]  mul_cnt_reg;
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic [15:0] shake_thr_reg;
    logic [14:0] spin_db_reg;
    logic [15:0] report_ivl_reg;
    logic [31:0] last_report_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gz_reg;
    logic [31:0] time_reg;
    logic [36:0] prod_reg;
    logic [30:0] sxx_reg;
    logic [31:0] syz_reg;
    logic [15:0] spin_reg;
    logic [31:0] sq_v_reg;
    logic [18:0] sq_rem_reg;
    logic [15:0] sq_root_reg;
    cordic_t     cord_reg;
    logic        zero_reg;
    logic signed [15:0] roll_reg;

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

    function automatic cordic_t cordic_init(input logic signed [16:0] num,
                                            input logic signed [16:0] den);
        cordic_t c;
        logic signed [CORDIC_W-1:0] x0, y0;
        x0 = CORDIC_W'({den, 8'b0});
        y0 = CORDIC_W'({num, 8'b0});
        x0 = {{(CORDIC_W-25){den[16]}}, den, 8'b0};
        y0 = {{(CORDIC_W-25){num[16]}}, num, 8'b0};
        c.x = x0;
        c.y = y0;
        c.acc = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                c.x = y0;
                c.y = -x0;
                c.acc = ANGLE_90;
            end else begin
                c.x = -y0;
                c.y = x0;
                c.acc = -ANGLE_90;
            end
        end
        return c;
    endfunction

    function automatic logic signed [15:0] angle_out(input logic signed [ANGLE_W-1:0] acc,
                                                     input logic zero,
                                                     input logic signed [17:0] lim);
        logic signed [ANGLE_W:0] sum;
        logic signed [17:0] q;
        sum = {acc[ANGLE_W-1], acc} + (ANGLE_W+1)'(256);
        q = sum[ANGLE_W:9];
        if (q > lim) begin
            q = lim;
        end
        if (q < -lim) begin
            q = -lim;
        end
        if (zero) begin
            q = '0;
        end
        return q[15:0];
    endfunction

    // shared multiplier
    logic [16:0] mul_a;
    logic [21:0] mul_b;
    logic [36:0] prod_next;
    logic [36:0] spin_sum;

    always_comb begin
        mul_a = abs16(gz_reg);
        mul_b = SPIN_K;
        case (mul_cnt_reg)
            3'd0: begin
                mul_a = abs16(ax_reg);
                mul_b = 22'(abs16(ax_reg));
            end
            3'd1: begin
                mul_a = abs16(ay_reg);
                mul_b = 22'(abs16(ay_reg));
            end
            3'd2: begin
                mul_a = abs16(az_reg);
                mul_b = 22'(abs16(az_reg));
            end
            default: ;
        endcase
    end

    assign prod_next = 37'(mul_a * mul_b);
    assign spin_sum  = prod_reg + 37'(1 << 20);

    // shared square root unit, one result bit a step
    logic [18:0] rem_sh, trial, sq_rem_next;
    logic        sq_ge;
    logic [15:0] sq_root_next;
    logic [31:0] sq_v_next;

    always_comb begin
        rem_sh       = {sq_rem_reg[16:0], sq_v_reg[31:30]};
        trial        = {1'b0, sq_root_reg, 2'b01};
        sq_ge        = rem_sh >= trial;
        sq_rem_next  = sq_ge ? rem_sh - trial : rem_sh;
        sq_root_next = {sq_root_reg[14:0], sq_ge};
        sq_v_next    = {sq_v_reg[29:0], 2'b00};
    end

    // shared CORDIC vectoring unit, one rotation a step
    cordic_t cord_next;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ANGLE_W-1:0]  atan_step;

    always_comb begin
        xs = cord_reg.x >>> cnt_reg;
        ys = cord_reg.y >>> cnt_reg;
        atan_step = ANGLE_W'(atan_entry(5'(cnt_reg)));
        if (cord_reg.y >= 0) begin
            cord_next.x   = cord_reg.x + ys;
            cord_next.y   = cord_reg.y - xs;
            cord_next.acc = cord_reg.acc + atan_step;
        end else begin
            cord_next.x   = cord_reg.x - ys;
            cord_next.y   = cord_reg.y + xs;
            cord_next.acc = cord_reg.acc - atan_step;
        end
    end

    logic sq_run, cord_run;
    assign sq_run   = ({1'b0, cnt_reg} < (CNT_W+1)'(SQRT_STEPS));
    assign cord_run = ({1'b0, cnt_reg} < (CNT_W+1)'(CORDIC_STEPS));

    // result assembly
    logic signed [15:0] pitch_full;
    logic        shake_c, report_c;
    logic [1:0]  dir_c;
    logic [31:0] dt;
    logic signed [16:0] gz_ext, db_ext;

    always_comb begin
        pitch_full = angle_out(cord_reg.acc, zero_reg, PITCH_LIM);
        shake_c    = sq_root_reg > shake_thr_reg;
        dt         = time_reg - last_report_reg;
        report_c   = (dt > {16'b0, report_ivl_reg}) || shake_c;
        gz_ext     = {gz_reg[15], gz_reg};
        db_ext     = {2'b00, spin_db_reg};
        if (gz_ext > db_ext) begin
            dir_c = SPIN_CW;
        end else if (gz_ext < -db_ext) begin
            dir_c = SPIN_CCW;
        end else begin
            dir_c = SPIN_NONE;
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            mul_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
            shake_thr_reg   <= SHAKE_THR_RST;
            spin_db_reg     <= SPIN_DB_RST;
            report_ivl_reg  <= REPORT_IVL_RST;
            last_report_reg <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SHAKE_THR:  shake_thr_reg  <= cfg_data;
                    REG_SPIN_DB:    spin_db_reg    <= cfg_data[14:0];
                    REG_REPORT_IVL: report_ivl_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        mul_cnt_reg <= '0;
                        state_reg   <= S_MUL;
                    end
                end
                S_MUL: begin
                    mul_cnt_reg <= mul_cnt_reg + 3'd1;
                    if (mul_cnt_reg == 3'd4) begin
                        state_reg <= S_LOAD1;
                    end
                end
                S_LOAD1: begin
                    cnt_reg   <= '0;
                    state_reg <= S_RUN1;
                end
                S_RUN1: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == RUN_LAST) begin
                        state_reg <= S_LOAD2;
                    end
                end
                S_LOAD2: begin
                    cnt_reg   <= '0;
                    state_reg <= S_RUN2;
                end
                S_RUN2: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == RUN_LAST) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'b0, report_c, dir_c, spin_reg, shake_c,
                                         sq_root_reg, pitch_full[14:0], roll_reg};
                        if (report_c) begin
                            last_report_reg <= time_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                ax_reg   <= s_tdata[15:0];
                ay_reg   <= s_tdata[31:16];
                az_reg   <= s_tdata[47:32];
                gz_reg   <= s_tdata[63:48];
                time_reg <= s_tdata[95:64];
            end
            S_MUL: begin
                if (mul_cnt_reg != 3'd4) begin
                    prod_reg <= prod_next;
                end
                case (mul_cnt_reg)
                    3'd1:    sxx_reg  <= prod_reg[30:0];
                    3'd2:    syz_reg  <= prod_reg[31:0];
                    3'd3:    syz_reg  <= syz_reg + prod_reg[31:0];
                    3'd4:    spin_reg <= spin_sum[36:21];
                    default: ;
                endcase
            end
            S_LOAD1: begin
                cord_reg    <= cordic_init({ay_reg[15], ay_reg}, {az_reg[15], az_reg});
                zero_reg    <= (ay_reg == '0) && (az_reg == '0);
                sq_v_reg    <= syz_reg;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            S_LOAD2: begin
                roll_reg    <= angle_out(cord_reg.acc, zero_reg, ROLL_LIM);
                cord_reg    <= cordic_init(-{ax_reg[15], ax_reg}, {1'b0, sq_root_reg});
                zero_reg    <= (ax_reg == '0) && (sq_root_reg == '0);
                sq_v_reg    <= syz_reg + {1'b0, sxx_reg};
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            S_RUN1, S_RUN2: begin
                if (sq_run) begin
                    sq_v_reg    <= sq_v_next;
                    sq_rem_reg  <= sq_rem_next;
                    sq_root_reg <= sq_root_next;
                end
                if (cord_run) begin
                    cord_reg <= cord_next;
                end
            end
            default: ;
        endcase
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule
